// File: src/big_endian_byte_memory_core_macros.svh
// Assertion macros shared by the RTL; clocked on clk, disabled while rst_n is low.
`ifndef BIG_ENDIAN_BYTE_MEMORY_CORE_MACROS_SVH
`define BIG_ENDIAN_BYTE_MEMORY_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define BEMC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BEMC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define BEMC_ASSERT(label, prop, msg)
`define BEMC_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// File: src/bemc_pkg.sv
package bemc_pkg;

    localparam int DEFAULT_MEM_BYTES = 4096;
    localparam int LANES             = 8;
    localparam int LANE_W            = 3;
    localparam int DEFAULT_ROWS      = (DEFAULT_MEM_BYTES + LANES - 1) / LANES;

    localparam int SIZE_W = 13;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

    localparam int ADDR_W  = 32;
    localparam int DATA_W  = 64;
    localparam int WIDTH_W = 2;

    typedef enum logic [0:0] {
        KIND_READ  = 1'b0,
        KIND_WRITE = 1'b1
    } kind_t;

    typedef enum logic [WIDTH_W-1:0] {
        WIDTH_1 = 2'd0,
        WIDTH_2 = 2'd1,
        WIDTH_4 = 2'd2,
        WIDTH_8 = 2'd3
    } width_code_t;

    // Access held while the bank read is in flight
    typedef struct packed {
        logic              rd;
        logic              oob;
        width_code_t       width_code;
        logic [LANE_W-1:0] lane0;
    } access_t;

endpackage

// File: src/bemc_bank.sv
module bemc_bank
    import bemc_pkg::*;
#(
    parameter int ROWS = DEFAULT_ROWS,
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [ROW_W-1:0] row,
    input  logic [7:0]       wdata,
    output logic [7:0]       rdata
);

    logic [7:0] mem [ROWS];
    logic [7:0] rdata_reg;

    // No reset: contents are undefined until written
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[row] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[row];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/big_endian_byte_memory_core.sv
// Pipeline: bank read stage, then assemble into the output register; one access
// per cycle while m_axis_tready keeps up, unaligned 8-byte accesses included,
// since the store is split into eight byte banks, each touched at most once.
// Reset: clears the pipeline valids and loads mem_size_bytes with 4096.
// Reset leaves the byte banks untouched; their contents are undefined until written.
`include "big_endian_byte_memory_core_macros.svh"

module big_endian_byte_memory_core
    import bemc_pkg::*;
#(
    parameter int MEM_BYTES = DEFAULT_MEM_BYTES
)
(
    input  logic              clk,
    input  logic              rst_n,

    // Size register write port
    input  logic              mem_size_bytes_we,
    input  logic [SIZE_W-1:0] mem_size_bytes_wdata,

    // Request stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [95:0]       s_axis_tdata,  // address[31:0], write_data[95:32]
    input  logic [2:0]        s_axis_tuser,  // kind[0], width_code[2:1]

    // Result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [63:0]       m_axis_tdata,  // read_data[63:0]
    output logic [0:0]        m_axis_tuser   // out_of_bounds[0]
);

    localparam int ROWS  = (MEM_BYTES + LANES - 1) / LANES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [ADDR_W:0] MEM_LIMIT = (ADDR_W + 1)'(MEM_BYTES);

    // ------------------------------------------------------------------
    // Size register
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] mem_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_size_reg <= SIZE_RESET;
        end
        else if (mem_size_bytes_we)
        begin
            mem_size_reg <= mem_size_bytes_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    kind_t             acc_kind;
    width_code_t       acc_width;
    logic [ADDR_W-1:0] acc_addr;
    logic [DATA_W-1:0] acc_wdata;
    logic [3:0]        acc_nbytes;
    logic [ADDR_W:0]   acc_end;
    logic [ADDR_W:0]   eff_size;
    logic              acc_oob;
    logic              in_xfer;

    assign acc_kind   = kind_t'(s_axis_tuser[0]);
    assign acc_width  = width_code_t'(s_axis_tuser[2:1]);
    assign acc_addr   = s_axis_tdata[31:0];
    assign acc_wdata  = s_axis_tdata[95:32];
    assign acc_nbytes = 4'd1 << acc_width;
    assign in_xfer    = s_axis_tvalid && s_axis_tready;

    // Clamp the programmed size to the physical store, then check the last byte
    always_comb
    begin
        eff_size = (ADDR_W + 1)'(mem_size_reg);
        if (eff_size > MEM_LIMIT)
        begin
            eff_size = MEM_LIMIT;
        end
        acc_end = {1'b0, acc_addr} + (ADDR_W + 1)'(acc_nbytes);
        acc_oob = acc_end > eff_size;
    end

    // ------------------------------------------------------------------
    // Bank steering: byte i of the access lives in bank (addr + i) mod 8.
    // Banks below the start lane hold the bytes that wrapped into the next row.
    // ------------------------------------------------------------------
    logic [LANE_W-1:0] lane0;
    logic [ROW_W-1:0]  row_base;
    logic [ROW_W-1:0]  bank_row   [LANES];
    logic [7:0]        bank_wdata [LANES];
    logic [7:0]        bank_rdata [LANES];
    logic [LANES-1:0]  bank_we;
    logic              bank_re;

    assign lane0    = acc_addr[LANE_W-1:0];
    assign row_base = acc_addr[ROW_W+LANE_W-1:LANE_W];
    assign bank_re  = in_xfer && (acc_kind == KIND_READ) && !acc_oob;

    always_comb
    begin
        logic [LANE_W-1:0] idx;
        logic [LANE_W-1:0] src;
        for (int b = 0; b < LANES; b++)
        begin
            idx           = LANE_W'(b) - lane0;
            src           = LANE_W'(acc_nbytes - 4'd1 - {1'b0, idx});
            bank_row[b]   = row_base + ROW_W'(LANE_W'(b) < lane0);
            bank_we[b]    = in_xfer && (acc_kind == KIND_WRITE) && !acc_oob
                            && ({1'b0, idx} < acc_nbytes);
            // The most significant used byte goes to the lowest address
            bank_wdata[b] = acc_wdata[8*src +: 8];
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_bank
        bemc_bank #(
            .ROWS (ROWS)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we[g]),
            .re    (bank_re),
            .row   (bank_row[g]),
            .wdata (bank_wdata[g]),
            .rdata (bank_rdata[g])
        );
    end

    // ------------------------------------------------------------------
    // Read stage: hold the access while the banks return data
    // ------------------------------------------------------------------
    logic    s1_valid_reg;
    logic    s1_valid_next;
    access_t s1_reg;
    logic    s1_adv;
    logic    out_valid_reg;
    logic    out_valid_next;

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_reg.rd         <= (acc_kind == KIND_READ) && !acc_oob;
            s1_reg.oob        <= acc_oob;
            s1_reg.width_code <= acc_width;
            s1_reg.lane0      <= lane0;
        end
    end

    // ------------------------------------------------------------------
    // Assemble: place byte i at the top, then right-align to the width
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] packed_be;
    logic [DATA_W-1:0] read_value;
    logic [3:0]        s1_nbytes;

    assign s1_nbytes = 4'd1 << s1_reg.width_code;

    always_comb
    begin
        logic [LANE_W-1:0] lane;
        packed_be = '0;
        for (int i = 0; i < LANES; i++)
        begin
            lane = s1_reg.lane0 + LANE_W'(i);
            if (4'(i) < s1_nbytes)
            begin
                packed_be[DATA_W-1-8*i -: 8] = bank_rdata[lane];
            end
        end

        unique case (s1_reg.width_code)
            WIDTH_1: read_value = packed_be >> 56;
            WIDTH_2: read_value = packed_be >> 48;
            WIDTH_4: read_value = packed_be >> 32;
            WIDTH_8: read_value = packed_be;
            default: read_value = '0;
        endcase

        // Drop the data of writes and failed accesses
        if (!s1_reg.rd)
        begin
            read_value = '0;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] out_data_reg;
    logic              out_oob_reg;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg <= read_value;
            out_oob_reg  <= s1_reg.oob;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_oob_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `BEMC_ASSERT(a_stall_needs_s1, !s_axis_tready |-> s1_valid_reg, "empty stage stalls")
    `BEMC_ASSERT(a_no_oob_write, (|bank_we) |-> !acc_oob, "write past bound")
    `BEMC_ASSERT(a_oob_zero, out_valid_reg && out_oob_reg |-> out_data_reg == '0, "oob data")
    `BEMC_ASSERT_NEXT(a_advance_fills_out, s1_adv, out_valid_reg, "advance lost")

endmodule

// File: bench/big_endian_byte_memory_core_tb.sv
module big_endian_byte_memory_core_tb;

    import bemc_pkg::*;

    // Size of the byte store inside the block, and the timing limits of the bench
    localparam int STORE_BYTES    = DEFAULT_MEM_BYTES;
    localparam int WATCHDOG_LIMIT = 4000;   // cycles without any transfer
    localparam int DRAIN_CYCLES   = 10;     // extra wait after the last reply
    localparam int HOLD_CYCLES    = 400;    // long receiver hold-off

    // One expected reply of the memory: read value and bounds flag
    typedef struct {
        logic [DATA_W-1:0] read_data;
        logic              out_of_bounds;
    } mem_reply_t;

    // Scoreboard: keeps a byte image of the memory, predicts each reply and
    // holds the predicted replies in transfer order until the block returns them.
    class byte_mem_scoreboard;
        logic [7:0]        byte_image [STORE_BYTES];
        bit                written    [STORE_BYTES];
        logic [SIZE_W-1:0] size_reg;
        mem_reply_t        expected_replies [$];
        int unsigned       n_reads;
        int unsigned       n_writes;
        int unsigned       n_oob;
        int unsigned       replies_checked;

        function new();
            size_reg = SIZE_RESET;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function void set_size(logic [SIZE_W-1:0] v);
            size_reg = v;
        endfunction

        // Bounds use the register value saturated to the real store size
        function logic [SIZE_W-1:0] effective_size();
            return (size_reg > STORE_BYTES) ? SIZE_W'(STORE_BYTES) : size_reg;
        endfunction

        function bit beyond_size(logic [ADDR_W-1:0] a, width_code_t w);
            return ({32'd0, a} + 64'(1 << int'(w))) > 64'(effective_size());
        endfunction

        // True when every byte of an in-bounds access has been stored before
        function bit span_written(logic [ADDR_W-1:0] a, width_code_t w);
            int unsigned nbytes;
            nbytes = 1 << int'(w);
            for (int unsigned i = 0; i < nbytes; i++)
                if (!written[a + i]) return 1'b0;
            return 1'b1;
        endfunction

        function int unsigned pending();
            return expected_replies.size();
        endfunction

        // Apply one accepted access to the image and queue its reply
        function void note_access(kind_t k, width_code_t w, logic [ADDR_W-1:0] a,
                                  logic [DATA_W-1:0] d);
            mem_reply_t  r;
            int unsigned nbytes;
            int unsigned pos;
            nbytes          = 1 << int'(w);
            r.read_data     = '0;
            r.out_of_bounds = 1'b0;
            if (k == KIND_WRITE) n_writes++;
            else n_reads++;
            if (beyond_size(a, w)) begin
                r.out_of_bounds = 1'b1;
                n_oob++;
            end
            else if (k == KIND_WRITE) begin
                // Most significant used byte lands at the lowest address
                for (int unsigned i = 0; i < nbytes; i++) begin
                    pos             = a + i;
                    byte_image[pos] = d[8*(nbytes-1-i) +: 8];
                    written[pos]    = 1'b1;
                end
            end
            else begin
                for (int unsigned i = 0; i < nbytes; i++) begin
                    pos         = a + i;
                    r.read_data = {r.read_data[DATA_W-9:0], byte_image[pos]};
                end
            end
            expected_replies.push_back(r);
        endfunction

        // Compare one returned reply with the oldest prediction; empty string on match
        function string check_reply(logic [DATA_W-1:0] data, logic oob);
            mem_reply_t want;
            string      msg;
            replies_checked++;
            if (expected_replies.size() == 0)
                return $sformatf("reply with no access pending: read_data %h oob %b",
                                 data, oob);
            want = expected_replies.pop_front();
            msg  = "";
            if (data !== want.read_data)
                msg = {msg, $sformatf(" read_data %h, want %h", data, want.read_data)};
            if (oob !== want.out_of_bounds)
                msg = {msg, $sformatf(" out_of_bounds %b, want %b", oob, want.out_of_bounds)};
            if (msg != "")
                msg = $sformatf("reply %0d:%s", replies_checked, msg);
            return msg;
        endfunction
    endclass

    // Clock, reset and block inputs; every input is known from time zero
    logic              clk                  = 1'b0;
    logic              rst_n                = 1'b0;
    logic              mem_size_bytes_we    = 1'b0;
    logic [SIZE_W-1:0] mem_size_bytes_wdata = '0;
    logic              s_axis_tvalid        = 1'b0;
    logic              s_axis_tready;
    logic [95:0]       s_axis_tdata         = '0;  // address[31:0], write_data[95:32]
    logic [2:0]        s_axis_tuser         = '0;  // kind[0], width_code[2:1]
    logic              m_axis_tvalid;
    logic              m_axis_tready        = 1'b0;
    logic [63:0]       m_axis_tdata;                // read_data[63:0]
    logic [0:0]        m_axis_tuser;                // out_of_bounds[0]

    byte_mem_scoreboard sb = new();

    int unsigned mismatches    = 0;
    int unsigned size_settings = 0;
    bit          sender_burst  = 1'b0;

    big_endian_byte_memory_core #(
        .MEM_BYTES (STORE_BYTES)
    ) u_top (
        .clk                  (clk),
        .rst_n                (rst_n),
        .mem_size_bytes_we    (mem_size_bytes_we),
        .mem_size_bytes_wdata (mem_size_bytes_wdata),
        .s_axis_tvalid        (s_axis_tvalid),
        .s_axis_tready        (s_axis_tready),
        .s_axis_tdata         (s_axis_tdata),
        .s_axis_tuser         (s_axis_tuser),
        .m_axis_tvalid        (m_axis_tvalid),
        .m_axis_tready        (m_axis_tready),
        .m_axis_tdata         (m_axis_tdata),
        .m_axis_tuser         (m_axis_tuser)
    );

    // 10-unit period: five high, five low
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Print one line per mismatch and count it
    task automatic report_mismatch(string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Idle length: mostly none or short, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Offer one access and hold it until the block takes the transfer
    task automatic send_access(kind_t k, width_code_t w, logic [ADDR_W-1:0] a,
                               logic [DATA_W-1:0] d);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {d, a};
        s_axis_tuser  <= {w, k};
        @(posedge clk);
        while (s_axis_tready !== 1'b1) @(posedge clk);
        sb.note_access(k, w, a, d);
    endtask

    // Drop valid for a random stretch, unless the sender is in a burst
    task automatic sender_pause();
        int unsigned g;
        g = sender_burst ? 0 : pick_gap();
        if (g != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic push_access(kind_t k, width_code_t w, logic [ADDR_W-1:0] a,
                               logic [DATA_W-1:0] d);
        sender_pause();
        send_access(k, w, a, d);
    endtask

    // Change the size register only once every reply is back
    task automatic write_size(logic [SIZE_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        mem_size_bytes_we    <= 1'b1;
        mem_size_bytes_wdata <= v;
        @(posedge clk);
        mem_size_bytes_we    <= 1'b0;
        sb.set_size(v);
        size_settings++;
    endtask

    // Draw one access. Addresses cluster at the bottom of the store and
    // around the size limit so reads hit stored bytes and the bound is
    // exercised; some sit at the top of the 32-bit space and the rest are
    // spread over all of it. A read inside the bound must only cover bytes
    // already stored, so redraw, and fall back to a write after eight tries.
    function automatic void pick_access(output kind_t k, output width_code_t w,
                                        output logic [ADDR_W-1:0] a,
                                        output logic [DATA_W-1:0] d);
        int unsigned       region;
        logic [ADDR_W-1:0] lim;
        d   = {$urandom, $urandom};
        lim = ADDR_W'(sb.effective_size());
        k   = KIND_WRITE;
        w   = WIDTH_1;
        a   = '0;
        for (int tries = 0; tries < 8; tries++) begin
            k      = kind_t'($urandom_range(0, 1));
            w      = width_code_t'($urandom_range(0, 3));
            region = $urandom_range(0, 99);
            if (region < 60)      a = $urandom_range(0, 95);
            else if (region < 80) a = lim - $urandom_range(0, 16);
            else if (region < 85) a = 32'hFFFF_FFFF - $urandom_range(0, 15);
            else                  a = $urandom;
            if (k == KIND_WRITE || sb.beyond_size(a, w) || sb.span_written(a, w))
                return;
        end
        k = KIND_WRITE;
    endfunction

    task automatic run_random(int unsigned n);
        kind_t             k;
        width_code_t       w;
        logic [ADDR_W-1:0] a;
        logic [DATA_W-1:0] d;
        for (int unsigned i = 0; i < n; i++) begin
            // Re-pick burst mode now and then to get stretches with no idling
            if (i % 100 == 0) sender_burst = ($urandom_range(0, 3) == 0);
            pick_access(k, w, a, d);
            push_access(k, w, a, d);
        end
        sender_burst = 1'b0;
    endtask

    // Hand-picked accesses at the reset size of 4096 bytes
    task automatic run_directed();
        // Big-endian layout, aligned and unaligned reads of one stored word
        push_access(KIND_WRITE, WIDTH_8, 32'd0, 64'h0123_4567_89AB_CDEF);
        push_access(KIND_READ,  WIDTH_8, 32'd0, '1);
        push_access(KIND_READ,  WIDTH_4, 32'd4, '0);
        push_access(KIND_READ,  WIDTH_2, 32'd3, '0);
        push_access(KIND_READ,  WIDTH_1, 32'd7, '0);
        // Narrow write keeps only the low byte of the data
        push_access(KIND_WRITE, WIDTH_1, 32'd2, 64'hFFFF_FFFF_FFFF_FF5A);
        push_access(KIND_READ,  WIDTH_4, 32'd0, '0);
        // Accesses that straddle the eight-byte bank rows
        push_access(KIND_WRITE, WIDTH_8, 32'd8, 64'hFEDC_BA98_7654_3210);
        push_access(KIND_WRITE, WIDTH_4, 32'd13, 64'h0000_0000_DEAD_BEEF);
        push_access(KIND_WRITE, WIDTH_2, 32'd17, 64'h0000_0000_0000_A5C3);
        push_access(KIND_READ,  WIDTH_8, 32'd11, '0);
        // Last bytes of the store and the first ones past it
        push_access(KIND_WRITE, WIDTH_8, 32'd4088, '1);
        push_access(KIND_READ,  WIDTH_8, 32'd4088, '0);
        push_access(KIND_READ,  WIDTH_8, 32'd4089, '0);
        push_access(KIND_WRITE, WIDTH_1, 32'd4095, '0);
        push_access(KIND_READ,  WIDTH_1, 32'd4095, '0);
        push_access(KIND_WRITE, WIDTH_1, 32'd4096, '1);
        push_access(KIND_READ,  WIDTH_2, 32'd4095, '0);
        // Top of the address space must not wrap around to zero
        push_access(KIND_READ,  WIDTH_1, 32'hFFFF_FFFF, '0);
        push_access(KIND_WRITE, WIDTH_4, 32'hFFFF_FFFC, '1);
        push_access(KIND_READ,  WIDTH_2, 32'd4094, '0);
        push_access(KIND_READ,  WIDTH_8, 32'd0, '0);
    endtask

    // Result side: check every transfer, stall at random, and twice hold
    // off for a long stretch while the sender keeps offering accesses.
    initial
    begin : result_sink
        string       msg;
        int unsigned stall_left;
        int unsigned holds_done;
        int unsigned cyc;
        bit          free_run;
        stall_left = 0;
        holds_done = 0;
        cyc        = 0;
        free_run   = 1'b0;
        forever begin
            @(posedge clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
                msg = sb.check_reply(m_axis_tdata, m_axis_tuser[0]);
                if (msg != "") report_mismatch(msg);
            end
            cyc++;
            if (cyc % 128 == 0) free_run = ($urandom_range(0, 3) == 0);
            if (stall_left != 0)
                stall_left--;
            else if (holds_done < 2 && sb.replies_checked >= 300 * (holds_done + 1)) begin
                stall_left = HOLD_CYCLES;
                holds_done++;
            end
            else if (!free_run && $urandom_range(0, 99) < 25)
                stall_left = pick_gap();
            m_axis_tready <= (stall_left == 0);
        end
    end

    // Watchdog: end the run when no transfer moves for too long
    initial
    begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
                (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog expired after %0d idle cycles", idle_cycles);
        $display("big_endian_byte_memory_core_tb NOT OK");
        $finish;
    end

    // Main sequence: reset, directed accesses, then random phases over a
    // range of size settings, the extremes included.
    initial
    begin : stimulus
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        write_size(13'd8191);   // far above the store, saturates
        run_random(200);
        write_size(13'd0);      // every access out of bounds
        run_random(40);
        write_size(13'd1);
        run_random(30);
        write_size(13'd8);
        run_random(60);
        write_size(13'd100);
        run_random(250);
        write_size(13'd4095);
        run_random(250);
        write_size(13'd5000);
        run_random(150);
        repeat (2) begin
            write_size(SIZE_W'($urandom_range(0, 8191)));
            run_random(130);
        end
        write_size(SIZE_RESET);
        run_random(40);

        // Drain: wait for every reply, then an extra drain wait for strays
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d reads and %0d writes, %0d out of bounds, over %0d size settings",
                 sb.n_reads, sb.n_writes, sb.n_oob, size_settings);
        $display("checked %0d replies, %0d mismatches", sb.replies_checked, mismatches);
        if (mismatches == 0)
            $display("big_endian_byte_memory_core_tb OK");
        else
            $display("big_endian_byte_memory_core_tb NOT OK");
        $finish;
    end

endmodule
